/* rtl/core/assert_macros.svh */
// Assertion macros used by the top-level RTL file, which carries the checks.
// Every macro expects clk_i and rst_ni in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The property must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

/* rtl/core/dkbsc_pkg.sv */
// Shared types and constants of the dual-key byte stream cipher.
// No dependencies; every other RTL file but dkbsc_ram and assert_macros.svh imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dkbsc_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned KEY_IDX_W = 14;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned OFFSET_W  = 64;
  localparam int unsigned OFS_LOW_W = 32;
  localparam int unsigned CFG_LEN_W = 15;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DIV_CNT_W = 7;

  localparam logic [CFG_LEN_W-1:0] CFG_LEN_RESET   = 15'd120;
  localparam logic [DIV_CNT_W-1:0] DIV_ITERS_FULL  = 7'd64;
  localparam logic [DIV_CNT_W-1:0] DIV_ITERS_INDEX = 7'd14;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_SLOT = 3'd0,
    OP_LOAD_FILE = 3'd1,
    OP_SEEK      = 3'd2,
    OP_ENCRYPT   = 3'd3,
    OP_DECRYPT   = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_LEN = 1'b0,
    CFG_FILE_LEN = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_FETCH    = 3'd0,
    S_IDLE     = 3'd1,
    S_DIV_SLOT = 3'd2,
    S_DIV_FILE = 3'd3,
    S_DIV_LOAD = 3'd4
  } state_e;

  typedef enum logic [1:0] {
    DIV_SEEK_SLOT = 2'd0,
    DIV_SEEK_FILE = 2'd1,
    DIV_LOAD      = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic     accept;
    logic     xform;
    logic     wr_direct;
    logic     wr_wrap;
    logic     div_start;
    div_sel_e div_sel;
    logic     set_slot;
    logic     set_file;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic div_busy;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/dkbsc_intf.sv */
// Valid/ready channel interfaces for the cipher input and result streams.
// Depends on dkbsc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dkbsc_in_if import dkbsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [KEY_IDX_W-1:0] key_index;
  logic [BYTE_W-1:0]    key_byte;
  logic [OFFSET_W-1:0]  start_offset;
  logic [BYTE_W-1:0]    data_in;

  modport source (output valid, operation, key_index, key_byte, start_offset, data_in,
                  input ready);
  modport sink   (input valid, operation, key_index, key_byte, start_offset, data_in,
                  output ready);
endinterface

interface dkbsc_out_if import dkbsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_out;

  modport source (output valid, data_out, input ready);
  modport sink   (input valid, data_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/dual_key_byte_stream_cipher.sv */
// Dual-key byte stream cipher, top level. Encrypt/decrypt: one byte per cycle while
// the output is not stalled, result registered in the cycle after acceptance. Load:
// direct write, or, when KEY_DEPTH < 16384, a 14-step index wrap in the divider first.
// Seek: two 64-step passes of the radix-2 divider. Reset (rst_ni, async, active low)
// clears positions, offset and lengths (120); key stores are not cleared, and the block
// passes through its fetch state before it accepts its first transaction.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dual_key_byte_stream_cipher import dkbsc_pkg::*; #(
  parameter int unsigned KEY_DEPTH = 16384
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_LEN_W-1:0] cfg_wdata_i,
  dkbsc_in_if.sink                  in_ch,
  dkbsc_out_if.source               out_ch
);

  // Controller and datapath talk only through these two bundles.
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // The controller owns the handshake on the input side. It accepts a transaction
  // only in its idle state and only when the output register is free or being
  // drained in the same cycle, so every result has a place to land. Encrypt and
  // decrypt complete in the acceptance cycle; seeks move it through both divider
  // states; loads pass the refetch state, after the divider if the index wraps.
  dkbsc_ctrl #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_op_i     (in_ch.operation),
    .out_ready_i (out_ch.ready),
    .status_i    (status),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  // The datapath keeps both key stores, which are always read at the
  // positions the next byte will use, so a byte is transformed in the
  // acceptance cycle and lands in the output register. A seek divides the
  // offset by the slot length, then the quotient by the file length; a
  // load into a shallow store wraps its index through the same divider.
  dkbsc_dpath #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (in_ch.operation),
    .key_index_i    (in_ch.key_index),
    .key_byte_i     (in_ch.key_byte),
    .start_offset_i (in_ch.start_offset),
    .data_in_i      (in_ch.data_in),
    .out_ready_i    (out_ch.ready),
    .out_valid_o    (out_ch.valid),
    .data_out_o     (out_ch.data_out)
  );

  assign in_ch.ready = in_ready;

  // An accepted transaction always finds room in the output register.
  `ASSERT_ALWAYS(a_accept_has_room, (in_ch.valid && in_ch.ready) |-> (!out_ch.valid || out_ch.ready), "transaction accepted while output is blocked")
  // A transformed byte is on the output in the next cycle.
  `ASSERT_ALWAYS(a_xform_shows, cmd.xform |=> out_ch.valid, "transformed byte not presented")
  // The divider is never restarted in the middle of a division.
  `ASSERT_NEVER(a_div_restart, cmd.div_start && status.div_busy, "divider restarted while busy")
  // No transaction is taken while a division result is being consumed.
  `ASSERT_NEVER(a_no_accept_on_done, status.div_done && in_ch.ready, "input ready during divider completion")

endmodule

`default_nettype wire

/* rtl/core/dkbsc_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dkbsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/dkbsc_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, for seek and index wrap.
// Depends on dkbsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dkbsc_div import dkbsc_pkg::*; #(
  parameter int unsigned KEY_DEPTH = 16384,
  localparam int unsigned LW       = $clog2(KEY_DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [OFFSET_W-1:0]  dividend_i,
  input  wire logic [LW-1:0]        divisor_i,
  input  wire logic [DIV_CNT_W-1:0] iters_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic      [OFFSET_W-1:0]  quot_o,
  output logic      [LW-1:0]        rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [OFFSET_W-1:0]  dvd_q, dvd_d;
  logic [LW-1:0]        dsr_q, dsr_d;
  logic [LW-1:0]        rem_q, rem_d;
  logic [LW:0]          shifted;
  logic [LW:0]          diff;
  logic                 fits;

  assign shifted = {rem_q, dvd_q[OFFSET_W-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = iters_i;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift one dividend bit into the remainder, subtract where it fits
      dvd_d  = {dvd_q[OFFSET_W-2:0], fits};
      rem_d  = fits ? diff[LW-1:0] : shifted[LW-1:0];
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      busy_d = (cnt_q != DIV_CNT_W'(1));
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* rtl/core/dkbsc_ctrl.sv */
// Controller state machine of the cipher: handshake, op decode, seek and load sequencing.
// Depends on dkbsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dkbsc_ctrl import dkbsc_pkg::*; #(
  parameter int unsigned KEY_DEPTH = 16384
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [OP_W-1:0] in_op_i,
  input  wire logic            out_ready_i,
  input  wire status_t         status_i,
  output logic                 in_ready_o,
  output cmd_t                 cmd_o
);

  // index wrap is needed only when the store is shallower than the index range
  localparam bit LOAD_WRAP = (KEY_DEPTH < (1 << KEY_IDX_W));

  state_e state_q, state_d;
  logic   in_ready;
  logic   accept;
  op_e    op;

  assign op       = op_e'(in_op_i);
  assign in_ready = (state_q == S_IDLE) && (!status_i.out_valid || out_ready_i);
  assign accept   = in_valid_i && in_ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_FETCH: state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (op) inside
            OP_LOAD_SLOT, OP_LOAD_FILE: state_d = LOAD_WRAP ? S_DIV_LOAD : S_FETCH;
            OP_SEEK:                    state_d = S_DIV_SLOT;
            default:                    state_d = S_IDLE;
          endcase
        end
      end
      S_DIV_SLOT: if (status_i.div_done) state_d = S_DIV_FILE;
      S_DIV_FILE: if (status_i.div_done) state_d = S_IDLE;
      S_DIV_LOAD: if (status_i.div_done) state_d = S_FETCH;
      default:    state_d = S_FETCH;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op) inside
            OP_LOAD_SLOT, OP_LOAD_FILE: begin
              if (LOAD_WRAP) begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_sel   = DIV_LOAD;
              end else begin
                cmd_o.wr_direct = 1'b1;
              end
            end
            OP_SEEK: begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_sel   = DIV_SEEK_SLOT;
            end
            OP_ENCRYPT, OP_DECRYPT: cmd_o.xform = 1'b1;
            default: ;
          endcase
        end
      end
      S_DIV_SLOT: begin
        if (status_i.div_done) begin
          cmd_o.set_slot  = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SEEK_FILE;
        end
      end
      S_DIV_FILE: cmd_o.set_file = status_i.div_done;
      S_DIV_LOAD: cmd_o.wr_wrap  = status_i.div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FETCH;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = in_ready;

endmodule

`default_nettype wire

/* rtl/core/dkbsc_dpath.sv */
// Datapath of the cipher: key stores, positions, offset, divider, transform, output.
// Depends on dkbsc_pkg, dkbsc_ram and dkbsc_div.
`timescale 1ns / 1ps
`default_nettype none

module dkbsc_dpath import dkbsc_pkg::*; #(
  parameter int unsigned KEY_DEPTH = 16384,
  localparam int unsigned AW       = $clog2(KEY_DEPTH),
  localparam int unsigned LW       = $clog2(KEY_DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_LEN_W-1:0] cfg_wdata_i,
  input  wire cmd_t                 cmd_i,
  output status_t                   status_o,
  input  wire logic [OP_W-1:0]      operation_i,
  input  wire logic [KEY_IDX_W-1:0] key_index_i,
  input  wire logic [BYTE_W-1:0]    key_byte_i,
  input  wire logic [OFFSET_W-1:0]  start_offset_i,
  input  wire logic [BYTE_W-1:0]    data_in_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic      [BYTE_W-1:0]    data_out_o
);

  function automatic logic [LW-1:0] clamp_len(logic [CFG_LEN_W-1:0] v);
    if (v == '0) return LW'(1);
    if (32'(v) > 32'(KEY_DEPTH)) return LW'(KEY_DEPTH);
    return LW'(v);
  endfunction

  function automatic logic [BYTE_W-1:0] nibble_fold(logic [BYTE_W-1:0] v);
    return v ^ {v[3:0], 4'h0};
  endfunction

  // effective lengths, clamped when written
  logic [LW-1:0]        slen_q, flen_q;
  logic [AW-1:0]        slot_pos_q, slot_pos_d;
  logic [AW-1:0]        file_pos_q, file_pos_d;
  logic [OFS_LOW_W-1:0] ofs_q, ofs_d;
  logic                 out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]    data_out_q, data_out_d;

  // payload held across multi-cycle operations
  logic [OFS_LOW_W-1:0] ofs_hold_q;
  logic [BYTE_W-1:0]    kbyte_q;
  logic                 sel_file_q;

  logic                 slot_wrap, file_wrap;
  logic [BYTE_W-1:0]    ofs_key, slot_key, file_key, v;

  logic                 div_busy, div_done;
  logic [OFFSET_W-1:0]  div_dividend, div_quot;
  logic [LW-1:0]        div_divisor, div_rem;
  logic [DIV_CNT_W-1:0] div_iters;

  logic                 slot_we, file_we;
  logic [AW-1:0]        key_waddr;
  logic [BYTE_W-1:0]    key_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slen_q <= clamp_len(CFG_LEN_RESET);
      flen_q <= clamp_len(CFG_LEN_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SLOT_LEN: slen_q <= clamp_len(cfg_wdata_i);
        CFG_FILE_LEN: flen_q <= clamp_len(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_SEEK_SLOT: begin
        div_dividend = start_offset_i;
        div_divisor  = slen_q;
        div_iters    = DIV_ITERS_FULL;
      end
      DIV_SEEK_FILE: begin
        div_dividend = div_quot;
        div_divisor  = flen_q;
        div_iters    = DIV_ITERS_FULL;
      end
      default: begin
        div_dividend = {key_index_i, {(OFFSET_W - KEY_IDX_W){1'b0}}};
        div_divisor  = LW'(KEY_DEPTH);
        div_iters    = DIV_ITERS_INDEX;
      end
    endcase
  end

  dkbsc_div #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .iters_i    (div_iters),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign slot_wrap = (LW'(slot_pos_q) + LW'(1)) >= slen_q;
  assign file_wrap = (LW'(file_pos_q) + LW'(1)) >= flen_q;

  always_comb begin
    slot_pos_d = slot_pos_q;
    file_pos_d = file_pos_q;
    ofs_d      = ofs_q;
    if (cmd_i.xform) begin
      ofs_d = ofs_q + OFS_LOW_W'(1);
      if (slot_wrap) begin
        slot_pos_d = '0;
        file_pos_d = file_wrap ? '0 : file_pos_q + AW'(1);
      end else begin
        slot_pos_d = slot_pos_q + AW'(1);
      end
    end
    if (cmd_i.set_slot) begin
      slot_pos_d = div_rem[AW-1:0];
    end
    if (cmd_i.set_file) begin
      file_pos_d = div_rem[AW-1:0];
      ofs_d      = ofs_hold_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_pos_q  <= '0;
      file_pos_q  <= '0;
      ofs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_pos_q  <= slot_pos_d;
      file_pos_q  <= file_pos_d;
      ofs_q       <= ofs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ofs_hold_q <= start_offset_i[OFS_LOW_W-1:0];
      kbyte_q    <= key_byte_i;
      sel_file_q <= (op_e'(operation_i) == OP_LOAD_FILE);
    end
    data_out_q <= data_out_d;
  end

  // stores read at the next positions, so key bytes are ready at acceptance
  assign slot_we   = (cmd_i.wr_direct && (op_e'(operation_i) == OP_LOAD_SLOT)) ||
                     (cmd_i.wr_wrap && !sel_file_q);
  assign file_we   = (cmd_i.wr_direct && (op_e'(operation_i) == OP_LOAD_FILE)) ||
                     (cmd_i.wr_wrap && sel_file_q);
  assign key_waddr = cmd_i.wr_direct ? AW'(key_index_i) : div_rem[AW-1:0];
  assign key_wdata = cmd_i.wr_direct ? key_byte_i : kbyte_q;

  dkbsc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (slot_pos_d),
    .rdata_o (slot_key)
  );

  dkbsc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_DEPTH)
  ) u_file_ram (
    .clk_i   (clk_i),
    .we_i    (file_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (file_pos_d),
    .rdata_o (file_key)
  );

  assign ofs_key = ofs_q[7:0] ^ ofs_q[15:8] ^ ofs_q[23:16] ^ ofs_q[31:24];

  always_comb begin
    if (op_e'(operation_i) == OP_ENCRYPT) begin
      v = nibble_fold(data_in_i ^ ofs_key ^ slot_key) ^ file_key;
    end else begin
      v = nibble_fold(data_in_i ^ file_key) ^ slot_key ^ ofs_key;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    data_out_d  = data_out_q;
    if (cmd_i.xform) begin
      out_valid_d = 1'b1;
      data_out_d  = v;
    end
  end

  assign status_o.out_valid = out_valid_q;
  assign status_o.div_busy  = div_busy;
  assign status_o.div_done  = div_done;
  assign out_valid_o        = out_valid_q;
  assign data_out_o         = data_out_q;

endmodule

`default_nettype wire
